// ----- rtl/hrgb_pkg.sv -----
// ============================================================================
// hrgb_pkg
// Shared constants, types and sector decode for the HSL to RGB converter.
// ============================================================================
package hrgb_pkg;

   // Field widths
   localparam int COLOR_BITS = 8;
   localparam int COLOR_MAX  = (1 << COLOR_BITS) - 1;
   localparam int HUE_BITS   = 13;

   // Hue geometry in sixteenths of a degree
   localparam int HUE_FULL        = 5760;
   localparam int HUE_SECTOR      = 960;
   localparam int HUE_TWO_SECTORS = 1920;
   localparam int HUE_T_BITS      = 11;

   // Per-channel gain: +GAIN_HALF for chroma, -GAIN_HALF for zero, ramp for mid
   localparam int GAIN_HALF = HUE_SECTOR / 2;
   localparam int GAIN_BITS = 10;
   localparam int CN_BITS   = 2 * COLOR_BITS;

   // Channel numerator n = GAIN_HALF*M + cn*gain, quotient n / (HUE_SECTOR*M),
   // biased so that the numerator stays non-negative
   localparam int PROD_BITS = 27;
   localparam int QUO_BITS  = COLOR_BITS + 1;
   localparam int QUO_BIAS  = 1 << (COLOR_BITS - 1);
   localparam int DIVISOR   = HUE_SECTOR * COLOR_MAX;
   localparam int NUM_OFS   = GAIN_HALF * COLOR_MAX + QUO_BIAS * DIVISOR;
   localparam int NUM_BITS  = 26;

   // Reciprocal of the divisor, rounded up; exact for NUM_BITS + 18 <= shift
   localparam int RECIP_SHIFT = 44;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam int RECIP_BITS = 27;
   localparam int MULT_BITS  = NUM_BITS + RECIP_BITS;
   localparam int RES_BITS   = COLOR_BITS + 3;

   localparam int STAGES = 5;

   typedef enum logic [2:0] {
      SECT_RY = 3'd0,
      SECT_YG = 3'd1,
      SECT_GC = 3'd2,
      SECT_CB = 3'd3,
      SECT_BM = 3'd4,
      SECT_MR = 3'd5
   } sector_type;

   typedef enum logic [1:0] {
      CHAN_RED   = 2'd0,
      CHAN_GREEN = 2'd1,
      CHAN_BLUE  = 2'd2
   } chan_type;

   typedef enum logic [1:0] {
      ROLE_CHROMA = 2'd0,
      ROLE_MID    = 2'd1,
      ROLE_NONE   = 2'd2
   } role_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

   typedef struct packed {
      logic [CN_BITS-1:0]           chroma;
      logic signed [GAIN_BITS-1:0]  gain;
      logic [COLOR_BITS-1:0]        light;
   } chan_feed_type;

   // Which part of the color a channel carries in a given sector
   function automatic role_type chan_role(sector_type sec, chan_type ch);
      role_type role;
      role = ROLE_NONE;
      case (sec)
         SECT_RY: role = (ch == CHAN_RED)   ? ROLE_CHROMA :
                         (ch == CHAN_GREEN) ? ROLE_MID : ROLE_NONE;
         SECT_YG: role = (ch == CHAN_GREEN) ? ROLE_CHROMA :
                         (ch == CHAN_RED)   ? ROLE_MID : ROLE_NONE;
         SECT_GC: role = (ch == CHAN_GREEN) ? ROLE_CHROMA :
                         (ch == CHAN_BLUE)  ? ROLE_MID : ROLE_NONE;
         SECT_CB: role = (ch == CHAN_BLUE)  ? ROLE_CHROMA :
                         (ch == CHAN_GREEN) ? ROLE_MID : ROLE_NONE;
         SECT_BM: role = (ch == CHAN_BLUE)  ? ROLE_CHROMA :
                         (ch == CHAN_RED)   ? ROLE_MID : ROLE_NONE;
         default: role = (ch == CHAN_RED)   ? ROLE_CHROMA :
                         (ch == CHAN_BLUE)  ? ROLE_MID : ROLE_NONE;
      endcase
      return role;
   endfunction

   // Gain that a channel applies to the chroma numerator
   function automatic logic signed [GAIN_BITS-1:0] chan_gain(
      sector_type sec, chan_type ch, logic signed [GAIN_BITS-1:0] ramp);
      logic signed [GAIN_BITS-1:0] gain;
      gain = ramp;
      case (chan_role(sec, ch))
         ROLE_CHROMA: gain = GAIN_BITS'(GAIN_HALF);
         ROLE_MID:    gain = ramp;
         default:     gain = GAIN_BITS'(-GAIN_HALF);
      endcase
      return gain;
   endfunction

endpackage

// ----- rtl/hrgb_if.sv -----
// ============================================================================
// hrgb_if
// Request and response channels of the HSL to RGB converter.
// ============================================================================
interface hrgb_req_if;
   import hrgb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [HUE_BITS-1:0]   hue;
   logic [COLOR_BITS-1:0] saturation;
   logic [COLOR_BITS-1:0] lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

interface hrgb_rsp_if;
   import hrgb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] red;
   logic [COLOR_BITS-1:0] green;
   logic [COLOR_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue,
                   input ready);
   modport sink   (input valid, input red, input green, input blue,
                   output ready);
endinterface

// ----- rtl/hrgb_front.sv -----
// ============================================================================
// hrgb_front
// Stages one and two: hue wrap, sector and ramp decode, chroma product.
// ============================================================================
module hrgb_front (
   input  logic                            clock,
   input  hrgb_pkg::stage_en_type          en,
   input  logic [hrgb_pkg::HUE_BITS-1:0]   hue,
   input  logic [hrgb_pkg::COLOR_BITS-1:0] saturation,
   input  logic [hrgb_pkg::COLOR_BITS-1:0] lightness,
   output hrgb_pkg::chan_feed_type         feed_red,
   output hrgb_pkg::chan_feed_type         feed_green,
   output hrgb_pkg::chan_feed_type         feed_blue
);
   import hrgb_pkg::*;

   logic [HUE_BITS-1:0]   hue_ff, hue_in;
   logic [COLOR_BITS-1:0] sat_ff, light_ff;

   logic [COLOR_BITS:0]          two_light, light_dev;
   logic [COLOR_BITS-1:0]        span;
   logic [CN_BITS-1:0]           chroma;
   logic [1:0]                   pair;
   logic [HUE_T_BITS-1:0]        t_pos, tri_dist;
   logic                         upper;
   sector_type                   sector;
   logic signed [HUE_T_BITS:0]   ramp_wide;
   logic signed [GAIN_BITS-1:0]  ramp;

   chan_feed_type red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // Wrap hue past full circle
   always_comb begin
      hue_in = hue;
      if (hue >= HUE_BITS'(HUE_FULL)) begin
         hue_in = hue - HUE_BITS'(HUE_FULL);
      end
   end

   // Stage one: hold wrapped hue and inputs
   always_ff @(posedge clock) begin
      if (en.s1) begin
         hue_ff   <= hue_in;
         sat_ff   <= saturation;
         light_ff <= lightness;
      end
   end

   // Chroma numerator (M - |2l - M|) * s
   always_comb begin
      two_light = {light_ff, 1'b0};
      if (two_light >= (COLOR_BITS+1)'(COLOR_MAX)) begin
         light_dev = two_light - (COLOR_BITS+1)'(COLOR_MAX);
      end else begin
         light_dev = (COLOR_BITS+1)'(COLOR_MAX) - two_light;
      end
      span   = COLOR_BITS'(COLOR_MAX) - light_dev[COLOR_BITS-1:0];
      chroma = CN_BITS'(span) * CN_BITS'(sat_ff);
   end

   // Sector and triangle ramp within each pair of sectors
   always_comb begin
      if (hue_ff >= HUE_BITS'(2 * HUE_TWO_SECTORS)) begin
         pair  = 2'd2;
         t_pos = HUE_T_BITS'(hue_ff - HUE_BITS'(2 * HUE_TWO_SECTORS));
      end else if (hue_ff >= HUE_BITS'(HUE_TWO_SECTORS)) begin
         pair  = 2'd1;
         t_pos = HUE_T_BITS'(hue_ff - HUE_BITS'(HUE_TWO_SECTORS));
      end else begin
         pair  = 2'd0;
         t_pos = HUE_T_BITS'(hue_ff);
      end
      upper  = (t_pos >= HUE_T_BITS'(HUE_SECTOR));
      sector = sector_type'({pair, upper});
      if (upper) begin
         tri_dist = t_pos - HUE_T_BITS'(HUE_SECTOR);
      end else begin
         tri_dist = HUE_T_BITS'(HUE_SECTOR) - t_pos;
      end
      ramp_wide = (HUE_T_BITS+1)'(GAIN_HALF) - $signed({1'b0, tri_dist});
      ramp      = ramp_wide[GAIN_BITS-1:0];
   end

   // Pick each channel's gain
   always_comb begin
      red_in.chroma   = chroma;
      red_in.gain     = chan_gain(sector, CHAN_RED, ramp);
      red_in.light    = light_ff;
      green_in.chroma = chroma;
      green_in.gain   = chan_gain(sector, CHAN_GREEN, ramp);
      green_in.light  = light_ff;
      blue_in.chroma  = chroma;
      blue_in.gain    = chan_gain(sector, CHAN_BLUE, ramp);
      blue_in.light   = light_ff;
   end

   // Stage two: hold per-channel feed
   always_ff @(posedge clock) begin
      if (en.s2) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign feed_red   = red_ff;
   assign feed_green = green_ff;
   assign feed_blue  = blue_ff;

endmodule

// ----- rtl/hrgb_chan.sv -----
// ============================================================================
// hrgb_chan
// Stages three to five of one color channel: numerator, reciprocal
// division, final offset with clamp.
// ============================================================================
module hrgb_chan (
   input  logic                            clock,
   input  hrgb_pkg::stage_en_type          en,
   input  hrgb_pkg::chan_feed_type         feed,
   output logic [hrgb_pkg::COLOR_BITS-1:0] level
);
   import hrgb_pkg::*;

   logic signed [PROD_BITS-1:0] prod, num_wide;
   logic [NUM_BITS-1:0]         num_ff;
   logic [COLOR_BITS-1:0]       light3_ff, light4_ff;
   logic [MULT_BITS-1:0]        mult;
   logic [QUO_BITS-1:0]         quo_ff;
   logic signed [RES_BITS-1:0]  res;
   logic [COLOR_BITS-1:0]       level_ff, level_in;

   // Biased numerator: offset plus chroma times gain
   always_comb begin
      prod     = $signed({1'b0, feed.chroma}) * $signed(feed.gain);
      num_wide = prod + PROD_BITS'(NUM_OFS);
   end

   // Stage three: hold numerator
   always_ff @(posedge clock) begin
      if (en.s3) begin
         num_ff    <= num_wide[NUM_BITS-1:0];
         light3_ff <= feed.light;
      end
   end

   // Divide by multiplying with the rounded-up reciprocal
   assign mult = MULT_BITS'(num_ff) * MULT_BITS'(RECIP);

   // Stage four: hold biased quotient
   always_ff @(posedge clock) begin
      if (en.s4) begin
         quo_ff    <= mult[RECIP_SHIFT +: QUO_BITS];
         light4_ff <= light3_ff;
      end
   end

   // Remove bias, add lightness and clamp to full scale
   always_comb begin
      res = $signed({3'b000, light4_ff}) + $signed({2'b00, quo_ff})
            - RES_BITS'(QUO_BIAS);
      if (res[RES_BITS-1]) begin
         level_in = '0;
      end else if (res > RES_BITS'(COLOR_MAX)) begin
         level_in = COLOR_BITS'(COLOR_MAX);
      end else begin
         level_in = res[COLOR_BITS-1:0];
      end
   end

   // Stage five: output register
   always_ff @(posedge clock) begin
      if (en.s5) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

// ----- rtl/hsl_to_rgb_converter_unit.sv -----
// ============================================================================
// hsl_to_rgb_converter_unit
// Five-stage pipelined HSL to RGB color converter.
// ============================================================================
// Usage:
//   req carries one color per request: hue in 1/16 degree (values from 5760
//   wrap around the circle), saturation and lightness on 0..255.
//   rsp returns red, green and blue on 0..255, rounded to nearest.
//   Both channels move a request when valid and ready are high together.
// Pipeline and throughput:
//   rsp.valid rises once a taken request has passed every pipeline stage;
//   one request is taken every clock while rsp is ready. The depth is set
//   by the two multiplies per channel (chroma gain, reciprocal divide), each
//   with its own register stage.
// Reset:
//   Synchronous reset empties the pipeline; rsp.valid drops at the next
//   clock. Data registers are not reset.
// Stall:
//   When rsp is not ready the result holds. Each stage keeps advancing
//   while the stage ahead of it is empty, so bubbles close up and req stays
//   ready until every stage holds a request.
module hsl_to_rgb_converter_unit (
   input logic        clock,
   input logic        reset,
   hrgb_req_if.sink   req,
   hrgb_rsp_if.source rsp
);
   import hrgb_pkg::*;

   logic [STAGES-1:0] valid_ff, valid_in;
   stage_en_type      en;
   chan_feed_type     feed_red, feed_green, feed_blue;

   // Advance a stage when it is empty or the stage ahead advances
   always_comb begin
      en.s5 = !valid_ff[4] || rsp.ready;
      en.s4 = !valid_ff[3] || en.s5;
      en.s3 = !valid_ff[2] || en.s4;
      en.s2 = !valid_ff[1] || en.s3;
      en.s1 = !valid_ff[0] || en.s2;
   end

   // Valid bits travel with the data
   always_comb begin
      valid_in = valid_ff;
      if (en.s1) begin
         valid_in[0] = req.valid;
      end
      if (en.s2) begin
         valid_in[1] = valid_ff[0];
      end
      if (en.s3) begin
         valid_in[2] = valid_ff[1];
      end
      if (en.s4) begin
         valid_in[3] = valid_ff[2];
      end
      if (en.s5) begin
         valid_in[4] = valid_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req.ready = en.s1;
   assign rsp.valid = valid_ff[4];

   hrgb_front u_front (
      .clock      (clock),
      .en         (en),
      .hue        (req.hue),
      .saturation (req.saturation),
      .lightness  (req.lightness),
      .feed_red   (feed_red),
      .feed_green (feed_green),
      .feed_blue  (feed_blue)
   );

   hrgb_chan u_chan_red (
      .clock (clock),
      .en    (en),
      .feed  (feed_red),
      .level (rsp.red)
   );

   hrgb_chan u_chan_green (
      .clock (clock),
      .en    (en),
      .feed  (feed_green),
      .level (rsp.green)
   );

   hrgb_chan u_chan_blue (
      .clock (clock),
      .en    (en),
      .feed  (feed_blue),
      .level (rsp.blue)
   );

endmodule

// ----- rtl/hrgb_checker.sv -----
// ============================================================================
// hrgb_checker
// Port-level checks of the HSL to RGB converter, bound to the top level.
// ============================================================================
module hrgb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [hrgb_pkg::COLOR_BITS-1:0] rsp_red,
   input logic [hrgb_pkg::COLOR_BITS-1:0] rsp_green,
   input logic [hrgb_pkg::COLOR_BITS-1:0] rsp_blue
);

   // Hold a stalled response and its color
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled response changed or dropped");

   // Drop the response channel after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Accept requests whenever no response is waiting
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // Deliver a request once it has passed every stage while the receiver keeps taking
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready) |=> rsp_valid)
      else $error("response missing after pipeline latency");

endmodule

bind hsl_to_rgb_converter_unit hrgb_checker u_hrgb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_red   (rsp.red),
   .rsp_green (rsp.green),
   .rsp_blue  (rsp.blue)
);

// ----- test/tb_hsl_to_rgb_converter_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_hsl_to_rgb_converter_unit
// Self-checking bench for the pipelined HSL to RGB color converter. Each
// accepted request is converted by an exact integer model of the color math
// and queued. Every response is checked in order against that queue, channel
// by channel. The stimulus covers extremes, sector edges, hue wrap and random
// colors under varying request gaps and response stalls.
// ============================================================================
module tb_hsl_to_rgb_converter_unit;
   import hrgb_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int PHASE_COLORS = 400;

   typedef struct packed {
      logic [HUE_BITS-1:0]   hue;
      logic [COLOR_BITS-1:0] saturation;
      logic [COLOR_BITS-1:0] lightness;
   } hsl_color_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } rgb_color_type;

   logic clock = 1'b0;
   logic reset;

   hrgb_req_if color_req ();
   hrgb_rsp_if color_rsp ();

   rgb_color_type expected_rgb[$];
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;
   int       colors_sent    = 0;
   int       colors_checked = 0;
   int       error_count    = 0;
   int       quiet_cycles   = 0;

   hsl_to_rgb_converter_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (color_req),
      .rsp   (color_rsp)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scale one channel numerator to 0..M, round to nearest, clamp
   function automatic logic [COLOR_BITS-1:0] scale_channel(longint unsigned num);
      longint unsigned full;
      longint unsigned q;
      full = COLOR_MAX;
      q = (num + HUE_SECTOR * full) / (HUE_TWO_SECTORS * full);
      if (q > full) q = full;
      return COLOR_BITS'(q);
   endfunction

   // Exact HSL to RGB conversion over the common denominator 1920 * M^2
   function automatic rgb_color_type convert_hsl(hsl_color_type c);
      longint unsigned full, hue, s, l, light_dev, cn, t, tri_dist;
      longint unsigned chroma, ramp, base, r, g, b;
      sector_type      sec;
      rgb_color_type   res;
      full = COLOR_MAX;
      hue  = c.hue;
      s    = c.saturation;
      l    = c.lightness;
      if (hue >= HUE_FULL) hue = hue - HUE_FULL;
      light_dev = (2 * l >= full) ? (2 * l - full) : (full - 2 * l);
      cn        = (full - light_dev) * s;
      t         = hue % HUE_TWO_SECTORS;
      tri_dist  = (t >= HUE_SECTOR) ? (t - HUE_SECTOR) : (HUE_SECTOR - t);
      chroma    = HUE_TWO_SECTORS * cn;
      ramp      = 2 * cn * (HUE_SECTOR - tri_dist);
      base      = HUE_TWO_SECTORS * full * l - HUE_SECTOR * cn;
      sec       = sector_type'(3'(hue / HUE_SECTOR));
      r = 0;
      g = 0;
      b = 0;
      case (sec)
         SECT_RY: begin r = chroma; g = ramp;   end
         SECT_YG: begin r = ramp;   g = chroma; end
         SECT_GC: begin g = chroma; b = ramp;   end
         SECT_CB: begin g = ramp;   b = chroma; end
         SECT_BM: begin r = ramp;   b = chroma; end
         default: begin r = chroma; b = ramp;   end
      endcase
      res.red   = scale_channel(r + base);
      res.green = scale_channel(g + base);
      res.blue  = scale_channel(b + base);
      return res;
   endfunction

   // Report one channel that differs from the prediction
   function automatic void check_channel(string name, logic [COLOR_BITS-1:0] exp_val,
                                         logic [COLOR_BITS-1:0] act_val);
      if (act_val !== exp_val) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
      end
   endfunction

   // Randomly stall the response channel
   always @(posedge clock) begin
      color_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Check each response against the oldest prediction; watch for a hang
   always @(posedge clock) begin
      rgb_color_type exp_rgb;
      if (!reset) begin
         if (color_rsp.valid && color_rsp.ready) begin
            if (expected_rgb.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                        $time, color_rsp.red, color_rsp.green, color_rsp.blue);
            end else begin
               exp_rgb = expected_rgb.pop_front();
               check_channel("red", exp_rgb.red, color_rsp.red);
               check_channel("green", exp_rgb.green, color_rsp.green);
               check_channel("blue", exp_rgb.blue, color_rsp.blue);
               colors_checked++;
            end
         end
         if ((color_req.valid && color_req.ready) || (color_rsp.valid && color_rsp.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                     $time, QUIET_LIMIT, expected_rgb.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Send one request, with a random gap ahead of it, and queue its prediction
   task automatic send_color(input logic [HUE_BITS-1:0] hue,
                             input logic [COLOR_BITS-1:0] sat,
                             input logic [COLOR_BITS-1:0] light);
      hsl_color_type c;
      c = '{hue: hue, saturation: sat, lightness: light};
      while ($urandom_range(99) < send_idle_pct) begin
         color_req.valid <= 1'b0;
         @(posedge clock);
      end
      color_req.valid      <= 1'b1;
      color_req.hue        <= hue;
      color_req.saturation <= sat;
      color_req.lightness  <= light;
      @(posedge clock);
      while (!color_req.ready) @(posedge clock);
      expected_rgb.push_back(convert_hsl(c));
      colors_sent++;
   endtask

   // Hold off requests until every prediction has been matched
   task automatic wait_until_drained();
      color_req.valid <= 1'b0;
      while (expected_rgb.size() != 0) @(posedge clock);
   endtask

   // Black, white, full and zero saturation, both sides of mid lightness
   task automatic test_extremes();
      send_color(13'd0, 8'd0, 8'd0);
      send_color(13'd0, 8'd255, 8'd255);
      send_color(13'd0, 8'd255, 8'd0);
      send_color(13'd0, 8'd255, 8'd127);
      send_color(13'd0, 8'd255, 8'd128);
      send_color(13'd5759, 8'd255, 8'd128);
      send_color(13'd2000, 8'd0, 8'd128);
   endtask

   // Middle hue of every sector at full saturation, last hue at saturation 200
   task automatic test_sector_edges();
      for (int sec = 0; sec < 6; sec++) begin
         send_color(HUE_BITS'(sec * HUE_SECTOR + HUE_SECTOR / 2), 8'd255, 8'd128);
         send_color(HUE_BITS'(sec * HUE_SECTOR + HUE_SECTOR - 1), 8'd200, 8'd100);
      end
   endtask

   // Hue values past the full circle wrap back
   task automatic test_hue_wrap();
      send_color(HUE_BITS'(HUE_FULL), 8'd255, 8'd128);
      send_color(HUE_BITS'(HUE_FULL + HUE_SECTOR), 8'd180, 8'd90);
      send_color(13'h1FFF, 8'd255, 8'd255);
   endtask

   // Random colors with the given request gaps and response stalls
   task automatic test_random_colors(input int idle_pct, input int stall_pct);
      logic [HUE_BITS-1:0]   hue;
      logic [COLOR_BITS-1:0] sat;
      logic [COLOR_BITS-1:0] light;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_COLORS; i++) begin
         // mostly in-range hues, some past the full circle
         if ($urandom_range(99) < 15)
            hue = HUE_BITS'($urandom_range(8191, HUE_FULL));
         else
            hue = HUE_BITS'($urandom_range(HUE_FULL - 1, 0));
         sat   = ($urandom_range(9) == 0) ? {COLOR_BITS{1'($urandom_range(1))}} :
                                            COLOR_BITS'($urandom);
         light = ($urandom_range(9) == 0) ? {COLOR_BITS{1'($urandom_range(1))}} :
                                            COLOR_BITS'($urandom);
         send_color(hue, sat, light);
         if (i == PHASE_COLORS / 2) wait_until_drained();
      end
      wait_until_drained();
   endtask

   initial begin
      reset                = 1'b1;
      color_req.valid      <= 1'b0;
      color_req.hue        <= '0;
      color_req.saturation <= '0;
      color_req.lightness  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 22;
      recv_stall_pct = 47;
      test_extremes();
      test_sector_edges();
      test_hue_wrap();
      wait_until_drained();

      test_random_colors(22, 47);
      test_random_colors(47, 22);
      test_random_colors(0, 0);

      // Let any stray response surface
      repeat (STAGES + 10) @(posedge clock);
      if (expected_rgb.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses missing, expected 0 outstanding, actual %0d",
                  $time, expected_rgb.size(), expected_rgb.size());
      end

      $display("Converted %0d colors: extremes, sector edges, hue wrap and random",
               colors_sent);
      $display("colors under three gap/stall mixes; %0d checked, %0d mismatches",
               colors_checked, error_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
